>>> hw/rtl/fcst_pkg.sv
// Package for the fixed-capacity set table.
// Holds field widths, parameter defaults, request codes and sequencer states.
// No dependencies; compile first.
package fcst_pkg;

  localparam int CapacityDefault  = 16;
  localparam int ValueBitsDefault = 32;

  // Fixed field widths of the request and response channels
  localparam int ReqTypeW = 3;
  localparam int ItemW    = 32;
  localparam int SizeW    = 5;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_ADD      = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_CONTAINS = 3'd2,
    REQ_CLEAR    = 3'd3,
    REQ_LIST     = 3'd4
  } req_type_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_REM_RD,
    S_REM_WR,
    S_LIST_RD,
    S_LIST_OUT,
    S_EMIT
  } state_t;

endpackage

>>> hw/rtl/fcst_if.sv
// Valid/ready channel interfaces for the set table: request and response.
// Depends on fcst_pkg for field widths.
interface fcst_req_if;
  logic                         valid;
  logic                         ready;
  logic [fcst_pkg::ReqTypeW-1:0] req_type;
  logic [fcst_pkg::ItemW-1:0]    item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface fcst_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [fcst_pkg::SizeW-1:0] set_size;
  logic [fcst_pkg::ItemW-1:0] entry_value;
  logic                       entry_valid;
  logic                       last;

  modport source (output valid, output ok, output set_size, output entry_value,
                  output entry_valid, output last, input ready);
  modport sink   (input valid, input ok, input set_size, input entry_value,
                  input entry_valid, input last, output ready);
endinterface

>>> hw/rtl/fcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/fixed_capacity_set_table.sv
// Add/remove/contains: take the request, scan live entries (stops early on a hit),
// decide, then for remove read and write back the last entry, then load the result.
// Clear, unknown requests, a full add and an empty list go straight to the result.
// List: one result per entry. The single RAM read port scans one entry per cycle.
// Reset (synchronous) empties the set at once; stored values need no clearing pass.
// A finished result waits in an output register while the next request is taken.
module fixed_capacity_set_table #(
  parameter int CAPACITY   = fcst_pkg::CapacityDefault,
  parameter int VALUE_BITS = fcst_pkg::ValueBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  fcst_req_if.sink           req,
  fcst_rsp_if.source         rsp
);
  import fcst_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int ExtW = (VALUE_BITS > ItemW) ? VALUE_BITS : ItemW;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         idx, idx_next;
  logic [CW-1:0]         cmp_idx, cmp_idx_next;
  logic                  cmp_vld, cmp_vld_next;
  logic [ReqTypeW-1:0]   op, op_next;
  logic [VALUE_BITS-1:0] val, val_next;
  logic                  found, found_next;
  logic [CW-1:0]         slot, slot_next;
  logic                  res_ok, res_ok_next;

  logic                  out_valid, out_valid_next;
  logic                  out_ok, out_ok_next;
  logic [SizeW-1:0]      out_size, out_size_next;
  logic [ItemW-1:0]      out_value, out_value_next;
  logic                  out_entry_valid, out_entry_valid_next;
  logic                  out_last, out_last_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;

  logic [ExtW-1:0]       in_ext;
  logic [ExtW-1:0]       rd_ext;
  logic [VALUE_BITS-1:0] in_val;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  issue;
  logic                  hit;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         idx_p1;

  fcst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Width adaptation between the 32-bit ports and the stored value width
  assign in_ext = ExtW'(req.item_value);
  assign in_val = in_ext[VALUE_BITS-1:0];
  assign rd_ext = ExtW'(rdata);

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign issue     = (idx < count);
  assign hit       = cmp_vld && (rdata == val);
  assign cnt_m1    = count - CW'(1);
  assign idx_p1    = idx + CW'(1);

  assign rsp.valid       = out_valid;
  assign rsp.ok          = out_ok;
  assign rsp.set_size    = out_size;
  assign rsp.entry_value = out_value;
  assign rsp.entry_valid = out_entry_valid;
  assign rsp.last        = out_last;

  // Read address: scan and list walk idx, remove fetches the last entry
  always_comb begin
    case (state)
      S_REM_RD: raddr = cnt_m1[AW-1:0];
      default:  raddr = idx[AW-1:0];
    endcase
  end

  // Sequencer: next state, datapath updates and result loading
  always_comb begin
    state_next           = state;
    count_next           = count;
    idx_next             = idx;
    cmp_idx_next         = cmp_idx;
    cmp_vld_next         = 1'b0;
    op_next              = op;
    val_next             = val;
    found_next           = found;
    slot_next            = slot;
    res_ok_next          = res_ok;
    we                   = 1'b0;
    waddr                = slot[AW-1:0];
    wdata                = rdata;
    out_load             = 1'b0;
    out_ok_next          = out_ok;
    out_size_next        = out_size;
    out_value_next       = out_value;
    out_entry_valid_next = out_entry_valid;
    out_last_next        = out_last;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next  = req.req_type;
          val_next = in_val;
          idx_next = '0;
          case (req.req_type)
            REQ_ADD: begin
              if (count == CW'(CAPACITY)) begin
                res_ok_next = 1'b0;
                state_next  = S_EMIT;
              end else begin
                state_next = S_SCAN;
              end
            end
            REQ_REMOVE, REQ_CONTAINS: begin
              state_next = S_SCAN;
            end
            REQ_CLEAR: begin
              count_next  = '0;
              res_ok_next = 1'b1;
              state_next  = S_EMIT;
            end
            REQ_LIST: begin
              if (count == '0) begin
                res_ok_next = 1'b0;
                state_next  = S_EMIT;
              end else begin
                state_next = S_LIST_RD;
              end
            end
            default: begin
              res_ok_next = 1'b0;
              state_next  = S_EMIT;
            end
          endcase
        end
      end

      // Issue one read per cycle, compare the data returned from the last one
      S_SCAN: begin
        if (hit) begin
          found_next = 1'b1;
          slot_next  = cmp_idx;
          state_next = S_DECIDE;
        end else if (!issue) begin
          found_next = 1'b0;
          state_next = S_DECIDE;
        end else begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = idx;
          idx_next     = idx_p1;
        end
      end

      S_DECIDE: begin
        state_next = S_EMIT;
        case (op)
          REQ_ADD: begin
            res_ok_next = 1'b1;
            if (!found) begin
              we         = 1'b1;
              waddr      = count[AW-1:0];
              wdata      = val;
              count_next = count + CW'(1);
            end
          end
          REQ_REMOVE: begin
            res_ok_next = 1'b0;
            if (found) begin
              state_next = S_REM_RD;
            end
          end
          default: begin
            res_ok_next = found;
          end
        endcase
      end

      S_REM_RD: begin
        state_next = S_REM_WR;
      end

      // Move the last entry into the freed slot
      S_REM_WR: begin
        we          = 1'b1;
        waddr       = slot[AW-1:0];
        wdata       = rdata;
        count_next  = cnt_m1;
        res_ok_next = 1'b1;
        state_next  = S_EMIT;
      end

      S_LIST_RD: begin
        state_next = S_LIST_OUT;
      end

      // Hold the read address until the entry transfer can be loaded
      S_LIST_OUT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_ok_next          = 1'b1;
          out_size_next        = SizeW'(count);
          out_value_next       = rd_ext[ItemW-1:0];
          out_entry_valid_next = 1'b1;
          out_last_next        = (idx_p1 == count);
          idx_next             = idx_p1;
          state_next           = (idx_p1 == count) ? S_IDLE : S_LIST_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_ok_next          = res_ok;
          out_size_next        = SizeW'(count);
          out_value_next       = '0;
          out_entry_valid_next = 1'b0;
          out_last_next        = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_vld   <= cmp_vld_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    idx             <= idx_next;
    cmp_idx         <= cmp_idx_next;
    op              <= op_next;
    val             <= val_next;
    found           <= found_next;
    slot            <= slot_next;
    res_ok          <= res_ok_next;
    out_ok          <= out_ok_next;
    out_size        <= out_size_next;
    out_value       <= out_value_next;
    out_entry_valid <= out_entry_valid_next;
    out_last        <= out_last_next;
  end

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || rsp.ready))
    else $error("result loaded over an untaken transfer");

  a_append_has_room: assert property (@(posedge clk) disable iff (rst)
    (we && state == S_DECIDE) |-> (count < CW'(CAPACITY)))
    else $error("append into a full set");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_CLEAR) |=> (count == '0))
    else $error("clear did not empty the set");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx <= count))
    else $error("scan index past entry count");
`endif

endmodule
